// ===== hdl/tile_hash_dirty_tracker_macros.svh =====
// Assertion macros shared by the tracker RTL.
`ifndef TILE_HASH_DIRTY_TRACKER_MACROS_SVH
`define TILE_HASH_DIRTY_TRACKER_MACROS_SVH
`ifndef ASSERT_OFF
`define THDT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("tracker assertion failed");
`define THDT_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("tracker assertion failed");
`else
`define THDT_ASSERT(lbl, prop)
`define THDT_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// ===== hdl/thdt_pkg.sv =====
// Types and constants of the tile hash dirty tracker.
package thdt_pkg;

  localparam logic [1:0] REQ_PIXEL = 2'd0;
  localparam logic [1:0] REQ_FRAME = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;

  localparam logic [1:0] KIND_HASH     = 2'd0;
  localparam logic [1:0] KIND_DECISION = 2'd1;
  localparam logic [1:0] KIND_DIRTY    = 2'd2;

  localparam logic [1:0] CFG_TILE_COUNT     = 2'd0;
  localparam logic [1:0] CFG_RENDER_MODE    = 2'd1;
  localparam logic [1:0] CFG_FULL_THRESHOLD = 2'd2;

  localparam logic [1:0] MODE_FULL   = 2'd0;
  localparam logic [1:0] MODE_SPARSE = 2'd1;
  localparam logic [1:0] MODE_AUTO   = 2'd2;

  localparam logic [1:0] STEP_WIDTH  = 2'd0;
  localparam logic [1:0] STEP_HEIGHT = 2'd1;
  localparam logic [1:0] STEP_LO     = 2'd2;
  localparam logic [1:0] STEP_HI     = 2'd3;

  localparam logic [31:0] HASH_BASIS = 32'd2166136261;
  localparam logic [31:0] HASH_PRIME = 32'd16777619;
  localparam logic [6:0]  PCT_SCALE  = 7'd100;

  localparam logic [10:0] TILE_COUNT_RST     = 11'd150;
  localparam logic [1:0]  RENDER_MODE_RST    = MODE_AUTO;
  localparam logic [6:0]  FULL_THRESHOLD_RST = 7'd38;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_SCAN,
    ST_GATE,
    ST_MARK,
    ST_DIV,
    ST_FIN,
    ST_QRD,
    ST_EMIT
  } state_t;

endpackage

// ===== hdl/thdt_req_if.sv =====
// Request channel: pixels, frame ends and dirty queries.
interface thdt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [15:0] pixel;
  logic [9:0]  tile_index;
  logic [5:0]  tile_width;
  logic [5:0]  tile_height;
  logic        first_pixel;
  logic        last_pixel;
  logic        explicit_request;
  logic        force_full;

  modport source (output valid, req_type, pixel, tile_index, tile_width, tile_height,
                  first_pixel, last_pixel, explicit_request, force_full, input ready);
  modport sink (input valid, req_type, pixel, tile_index, tile_width, tile_height,
                first_pixel, last_pixel, explicit_request, force_full, output ready);
endinterface

// ===== hdl/thdt_rsp_if.sv =====
// Result channel: tile hashes, frame decisions and dirty answers.
interface thdt_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [31:0] tile_hash;
  logic        present;
  logic        full_flush;
  logic [10:0] dirty_count;
  logic [6:0]  dirty_percent;
  logic        tile_dirty;

  modport source (output valid, result_kind, tile_hash, present, full_flush, dirty_count,
                  dirty_percent, tile_dirty, input ready);
  modport sink (input valid, result_kind, tile_hash, present, full_flush, dirty_count,
                dirty_percent, tile_dirty, output ready);
endinterface

// ===== hdl/thdt_cfg_if.sv =====
// Configuration write channel.
interface thdt_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  addr;
  logic [10:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

// ===== hdl/tile_hash_dirty_tracker.sv =====
// Tile hash dirty tracker: FNV-1a tile hashing, frame decision and dirty map.
//
// The block hashes the pixels of each tile with 32-bit FNV-1a (width and height
// first on the first pixel, then low and high byte of every pixel) through one
// multiplier that takes one byte a cycle, and hands off a result when a pixel
// ends a tile. Scan, candidate and presented hashes and the dirty map sit in
// single-port-read synchronous memories of MAX_TILES entries. A frame end walks
// the tiles in use once to compare and refresh the candidates; if the stability
// gate passes, it then walks all MAX_TILES entries to rebuild the dirty map and
// the presented copy, then, if any tile is dirty, runs a bit-serial divider for
// the rounded-up percent. After reset the block clears the candidate, presented
// and dirty memories, one entry a cycle, before it takes a request;
// configuration writes are taken at any time. One item is in work at a time;
// a finished result waits in the output register while the next item is taken.
module tile_hash_dirty_tracker #(
  parameter int MAX_TILES = 1024
) (
  input logic        clk,
  input logic        rst,
  thdt_req_if.sink   req,
  thdt_rsp_if.source rsp,
  thdt_cfg_if.sink   cfg
);
  import thdt_pkg::*;

`include "tile_hash_dirty_tracker_macros.svh"

  localparam int AW  = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
  localparam int CW  = $clog2(MAX_TILES + 1);
  localparam int NW  = CW + 7;
  localparam int DCW = $clog2(NW + 1);
  localparam logic [CW-1:0]  LAST_TILE = CW'(MAX_TILES - 1);
  localparam logic [CW-1:0]  ALL_TILES = CW'(MAX_TILES);
  localparam logic [DCW-1:0] DIV_LAST  = DCW'(NW - 1);

  // Configuration registers
  logic [10:0] tile_count;
  logic [1:0]  render_mode;
  logic [6:0]  full_threshold;

  // Control state
  state_t      state, state_next;
  logic [31:0] running_hash;
  logic [1:0]  stable_scans;
  logic        pending_present;
  logic        pending_force;
  logic        force_l;
  logic        changed;
  logic [1:0]  hash_step;

  // Latched request
  logic [1:0]  lat_req;
  logic [15:0] lat_pix;
  logic [9:0]  lat_idx;
  logic [5:0]  lat_w;
  logic [5:0]  lat_h;
  logic        lat_last;

  // Table walk
  logic [CW-1:0] tiles_n;
  logic [CW-1:0] n_clamped;
  logic [CW-1:0] addr;
  logic [CW-1:0] addr_d;
  logic          rd_v;
  logic          issue;
  logic          walk_done;
  logic [CW-1:0] count;

  // Divider
  logic [NW-1:0]  div_num;
  logic [CW:0]    div_rem;
  logic [DCW-1:0] div_cnt;
  logic [CW:0]    rem_sh;
  logic           rem_ge;

  // Decision
  logic          dec_present;
  logic          dec_full;
  logic [CW-1:0] dec_count;
  logic [6:0]    dec_pct;
  logic          gate_go;
  logic          full_pick;

  // Output register
  logic        out_v;
  logic        emit;
  logic [1:0]  out_kind;
  logic [31:0] out_hash;
  logic        out_present;
  logic        out_full;
  logic [10:0] out_count;
  logic [6:0]  out_pct;
  logic        out_dirty;

  // Memories
  logic [31:0] scan_mem  [MAX_TILES];
  logic [31:0] cand_mem  [MAX_TILES];
  logic [31:0] pres_mem  [MAX_TILES];
  logic        dirty_mem [MAX_TILES];
  logic [31:0] scan_q, cand_q, pres_q;
  logic        dirty_q;

  logic          scan_we, cand_we, pres_we, dirty_we;
  logic [AW-1:0] cand_wa, pres_wa, dirty_wa;
  logic [31:0]   cand_wd, pres_wd;
  logic          dirty_wd;
  logic          idx_in_range;
  logic          tile_used;
  logic          tile_dirty_bit;
  logic [31:0]   hash_base;
  logic [7:0]    hash_byte;
  logic [31:0]   hash_mix;
  logic [31:0]   hash_fin;
  logic          req_fire;

  assign req.ready = (state == ST_IDLE);
  assign cfg.ready = 1'b1;
  assign req_fire  = req.valid && req.ready;

  assign rsp.valid         = out_v;
  assign rsp.result_kind   = out_kind;
  assign rsp.tile_hash     = out_hash;
  assign rsp.present       = out_present;
  assign rsp.full_flush    = out_full;
  assign rsp.dirty_count   = out_count;
  assign rsp.dirty_percent = out_pct;
  assign rsp.tile_dirty    = out_dirty;

  // Clamp the configured tile count into 1..MAX_TILES
  always_comb begin
    if (tile_count == 11'd0) begin
      n_clamped = CW'(1);
    end else if (32'(tile_count) > 32'(MAX_TILES)) begin
      n_clamped = ALL_TILES;
    end else begin
      n_clamped = CW'(tile_count);
    end
  end

  // Hash step: fold one byte into the running hash
  always_comb begin
    unique case (hash_step)
      STEP_WIDTH:  hash_byte = {2'b00, lat_w};
      STEP_HEIGHT: hash_byte = {2'b00, lat_h};
      STEP_LO:     hash_byte = lat_pix[7:0];
      STEP_HI:     hash_byte = lat_pix[15:8];
      default:     hash_byte = lat_pix[7:0];
    endcase
    hash_base = (hash_step == STEP_WIDTH) ? HASH_BASIS : running_hash;
    hash_mix  = (hash_base ^ {24'd0, hash_byte}) * HASH_PRIME;
    hash_fin  = (running_hash == 32'd0) ? 32'd1 : running_hash;
  end

  assign idx_in_range = (32'(lat_idx) < 32'(MAX_TILES));
  assign tile_used    = (addr_d < tiles_n);
  assign tile_dirty_bit = tile_used && (force_l || (cand_q != pres_q));

  // Walk: issue reads while the address is in range, compare in the cycle after
  always_comb begin
    issue = 1'b0;
    if (state == ST_SCAN) begin
      issue = (addr < tiles_n);
    end else if (state == ST_MARK) begin
      issue = (addr < ALL_TILES);
    end
    walk_done = !issue && !rd_v;
  end

  // Divider step
  assign rem_sh = {div_rem[CW-1:0], div_num[NW-1]};
  assign rem_ge = (rem_sh >= {1'b0, tiles_n});

  // Stability gate: a change, or no stable scan yet, defers the frame unless a present is pending
  always_comb begin
    if (changed) begin
      gate_go = pending_present;
    end else begin
      gate_go = pending_present || (stable_scans != 2'd0);
    end
  end

  always_comb begin
    full_pick = force_l || (render_mode == MODE_FULL);
    if (render_mode == MODE_AUTO && dec_pct >= full_threshold) begin
      full_pick = 1'b1;
    end
    if (render_mode == MODE_SPARSE) begin
      full_pick = 1'b0;
    end
  end

  assign emit    = (state == ST_EMIT) && (!out_v || rsp.ready);
  assign scan_we = emit && (lat_req == REQ_PIXEL) && idx_in_range;

  // Memory write ports
  always_comb begin
    cand_we  = 1'b0;
    cand_wa  = AW'(addr_d);
    cand_wd  = scan_q;
    pres_we  = 1'b0;
    pres_wa  = AW'(addr_d);
    pres_wd  = cand_q;
    dirty_we = 1'b0;
    dirty_wa = AW'(addr_d);
    dirty_wd = tile_dirty_bit;
    priority case (state)
      ST_CLEAR: begin
        cand_we  = 1'b1;
        cand_wa  = AW'(addr);
        cand_wd  = 32'd0;
        pres_we  = 1'b1;
        pres_wa  = AW'(addr);
        pres_wd  = 32'd0;
        dirty_we = 1'b1;
        dirty_wa = AW'(addr);
        dirty_wd = 1'b0;
      end
      ST_SCAN: begin
        cand_we = rd_v;
      end
      ST_MARK: begin
        pres_we  = rd_v && tile_used;
        dirty_we = rd_v;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (scan_we) begin
      scan_mem[AW'(lat_idx)] <= hash_fin;
    end
    scan_q <= scan_mem[AW'(addr)];
  end

  always_ff @(posedge clk) begin
    if (cand_we) begin
      cand_mem[cand_wa] <= cand_wd;
    end
    cand_q <= cand_mem[AW'(addr)];
  end

  always_ff @(posedge clk) begin
    if (pres_we) begin
      pres_mem[pres_wa] <= pres_wd;
    end
    pres_q <= pres_mem[AW'(addr)];
  end

  always_ff @(posedge clk) begin
    if (dirty_we) begin
      dirty_mem[dirty_wa] <= dirty_wd;
    end
    dirty_q <= dirty_mem[AW'(lat_idx)];
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (addr == LAST_TILE) state_next = ST_IDLE;
      ST_IDLE: begin
        if (req_fire) begin
          priority case (req.req_type)
            REQ_PIXEL: state_next = ST_HASH;
            REQ_FRAME: state_next = ST_SCAN;
            REQ_QUERY: state_next = ST_QRD;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_HASH: begin
        if (hash_step == STEP_HI) begin
          state_next = lat_last ? ST_EMIT : ST_IDLE;
        end
      end
      ST_SCAN: if (walk_done) state_next = ST_GATE;
      ST_GATE: state_next = gate_go ? ST_MARK : ST_EMIT;
      ST_MARK: begin
        if (walk_done) begin
          state_next = (count == '0) ? ST_EMIT : ST_DIV;
        end
      end
      ST_DIV:  if (div_cnt == DIV_LAST) state_next = ST_FIN;
      ST_FIN:  state_next = ST_EMIT;
      ST_QRD:  state_next = ST_EMIT;
      ST_EMIT: if (emit) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      tile_count     <= TILE_COUNT_RST;
      render_mode    <= RENDER_MODE_RST;
      full_threshold <= FULL_THRESHOLD_RST;
    end else if (cfg.valid && cfg.ready) begin
      priority case (cfg.addr)
        CFG_TILE_COUNT:     tile_count     <= cfg.data;
        CFG_RENDER_MODE:    render_mode    <= cfg.data[1:0];
        CFG_FULL_THRESHOLD: full_threshold <= cfg.data[6:0];
        default: begin
        end
      endcase
    end
  end

  // Control state and walk
  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash    <= HASH_BASIS;
      stable_scans    <= 2'd0;
      pending_present <= 1'b1;
      pending_force   <= 1'b1;
      addr            <= '0;
      rd_v            <= 1'b0;
      out_v           <= 1'b0;
    end else begin
      // Load on emit, drop once the beat is taken
      out_v  <= emit || (out_v && !rsp.ready);
      rd_v   <= issue;
      addr_d <= addr;
      unique case (state)
        ST_CLEAR: begin
          addr <= addr + CW'(1);
        end
        ST_IDLE: begin
          addr    <= '0;
          changed <= 1'b0;
          count   <= '0;
          if (req_fire) begin
            lat_req   <= req.req_type;
            lat_pix   <= req.pixel;
            lat_idx   <= req.tile_index;
            lat_w     <= req.tile_width;
            lat_h     <= req.tile_height;
            lat_last  <= req.last_pixel;
            hash_step <= req.first_pixel ? STEP_WIDTH : STEP_LO;
            tiles_n   <= n_clamped;
            if (req.req_type == REQ_FRAME) begin
              pending_present <= pending_present | req.explicit_request;
              pending_force   <= pending_force | req.force_full;
            end
          end
        end
        ST_HASH: begin
          running_hash <= hash_mix;
          hash_step    <= hash_step + 2'd1;
        end
        ST_SCAN: begin
          if (issue) addr <= addr + CW'(1);
          if (rd_v && scan_q != cand_q) changed <= 1'b1;
        end
        ST_GATE: begin
          addr        <= '0;
          dec_present <= 1'b0;
          dec_full    <= 1'b0;
          dec_count   <= '0;
          dec_pct     <= 7'd0;
          if (changed) begin
            stable_scans <= 2'd1;
          end else if (!pending_present && stable_scans < 2'd2) begin
            stable_scans <= stable_scans + 2'd1;
          end
          if (gate_go) begin
            force_l       <= pending_force;
            pending_force <= 1'b0;
          end
        end
        ST_MARK: begin
          if (issue) addr <= addr + CW'(1);
          if (rd_v && tile_dirty_bit) count <= count + CW'(1);
          if (walk_done) begin
            dec_count <= count;
            div_num   <= NW'(count) * NW'(PCT_SCALE) + NW'(tiles_n) - NW'(1);
            div_rem   <= '0;
            div_cnt   <= '0;
            if (count == '0) pending_present <= 1'b0;
          end
        end
        ST_DIV: begin
          div_rem <= rem_ge ? (rem_sh - {1'b0, tiles_n}) : rem_sh;
          div_num <= {div_num[NW-2:0], rem_ge};
          div_cnt <= div_cnt + DCW'(1);
          dec_pct <= {div_num[5:0], rem_ge};
        end
        ST_FIN: begin
          dec_present     <= 1'b1;
          dec_full        <= full_pick;
          pending_present <= 1'b0;
          stable_scans    <= 2'd2;
        end
        ST_QRD: begin
        end
        ST_EMIT: begin
        end
        default: begin
        end
      endcase
    end
  end

  // Output payload: load one result beat when the slot frees
  always_ff @(posedge clk) begin
    if (emit) begin
      out_hash    <= 32'd0;
      out_present <= 1'b0;
      out_full    <= 1'b0;
      out_count   <= 11'd0;
      out_pct     <= 7'd0;
      out_dirty   <= 1'b0;
      priority case (lat_req)
        REQ_PIXEL: begin
          out_kind <= KIND_HASH;
          out_hash <= hash_fin;
        end
        REQ_FRAME: begin
          out_kind    <= KIND_DECISION;
          out_present <= dec_present;
          out_full    <= dec_full;
          out_count   <= 11'(dec_count);
          out_pct     <= dec_present ? dec_pct : 7'd0;
        end
        default: begin
          out_kind  <= KIND_DIRTY;
          out_dirty <= idx_in_range && dirty_q;
        end
      endcase
    end
  end

  `THDT_ASSERT(a_hash_nonzero, rsp.valid && rsp.result_kind == KIND_HASH |-> rsp.tile_hash != 32'd0)
  `THDT_ASSERT(a_pct_range, rsp.valid |-> rsp.dirty_percent <= 7'd100)
  `THDT_ASSERT(a_present_count, rsp.valid && rsp.present |-> rsp.dirty_count != 11'd0)
  `THDT_ASSERT_NEXT(a_fin_settles, state == ST_FIN, stable_scans == 2'd2 && !pending_present)

endmodule
